[hdl/smbtw_pkg.sv]
// ---------------------------------------------------------------------------
// SMBIOS table walker package
// Shared result codes and the queue entry that the front end hands to the
// back end.
// ---------------------------------------------------------------------------
package smbtw_pkg;

    localparam logic [1:0] KIND_STRING      = 2'd0;
    localparam logic [1:0] KIND_STRUCT_DONE = 2'd1;
    localparam logic [1:0] KIND_TABLE_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR       = 2'd3;

    localparam logic [1:0] ERR_TRUNCATED    = 2'd0;
    localparam logic [1:0] ERR_NO_TERM      = 2'd1;
    localparam logic [1:0] ERR_STR_LONG     = 2'd2;

    localparam logic [7:0] END_TYPE         = 8'd127;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One accepted byte gives at most two results. They share the structure
    // context. The second one is always table done or an error, so it needs
    // only a kind and an error code.
    typedef struct packed {
        logic [7:0]  struct_type;
        logic [15:0] struct_handle;
        logic [31:0] struct_offset;
        logic [1:0]  kind0;
        logic [7:0]  index0;
        logic [31:0] str_off0;
        logic [15:0] str_len0;
        logic [1:0]  err0;
        logic        has2;
        logic [1:0]  kind1;
        logic [1:0]  err1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[hdl/smbtw_queue.sv]
// ---------------------------------------------------------------------------
// SMBIOS table walker result queue
// Short register queue between the byte front end and the result back end.
// ---------------------------------------------------------------------------
module smbtw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  smbtw_pkg::entry_t wdata,
    input  logic              pop,
    output smbtw_pkg::entry_t rdata,
    output smbtw_pkg::qstat_t stat
);

    smbtw_pkg::entry_t                 slot_reg [smbtw_pkg::QDEPTH];
    logic [smbtw_pkg::QPTR_W-1:0]      wptr_reg;
    logic [smbtw_pkg::QPTR_W-1:0]      wptr_next;
    logic [smbtw_pkg::QPTR_W-1:0]      rptr_reg;
    logic [smbtw_pkg::QPTR_W-1:0]      rptr_next;
    logic [smbtw_pkg::QCNT_W-1:0]      count_reg;
    logic [smbtw_pkg::QCNT_W-1:0]      count_next;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata      = slot_reg[rptr_reg];
    assign stat.full  = (count_reg == smbtw_pkg::QCNT_W'(smbtw_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[hdl/smbtw_front.sv]
// ---------------------------------------------------------------------------
// SMBIOS table walker front end
// Takes one table byte per transfer, tracks the structure layout and queues
// the results that the byte causes.
// ---------------------------------------------------------------------------
module smbtw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              buffer_end,
    input  smbtw_pkg::qstat_t qstat,
    output logic              push,
    output smbtw_pkg::entry_t entry
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_AREA    = 2'd1;
    localparam logic [1:0] PH_STRINGS = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    logic [1:0]  phase_reg,          phase_next;
    logic [1:0]  header_count_reg,   header_count_next;
    logic [7:0]  cur_type_reg,       cur_type_next;
    logic [7:0]  area_length_reg,    area_length_next;
    logic [15:0] cur_handle_reg,     cur_handle_next;
    logic [7:0]  area_remaining_reg, area_remaining_next;
    logic        seen_null_reg,      seen_null_next;
    logic [15:0] run_length_reg,     run_length_next;
    logic [7:0]  string_count_reg,   string_count_next;
    logic [31:0] string_start_reg,   string_start_next;
    logic [31:0] struct_start_reg,   struct_start_next;
    logic [31:0] byte_position_reg,  byte_position_next;

    logic        accept;
    logic [31:0] pos_inc;
    logic [7:0]  area_dec;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;
    assign pos_inc  = byte_position_reg + 32'd1;
    assign area_dec = area_remaining_reg - 8'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        cur_type_next       = cur_type_reg;
        area_length_next    = area_length_reg;
        cur_handle_next     = cur_handle_reg;
        area_remaining_next = area_remaining_reg;
        seen_null_next      = seen_null_reg;
        run_length_next     = run_length_reg;
        string_count_next   = string_count_reg;
        string_start_next   = string_start_reg;
        struct_start_next   = struct_start_reg;
        byte_position_next  = byte_position_reg;
        push                = 1'b0;
        entry               = '0;

        if (accept)
        begin
            byte_position_next = pos_inc;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (header_count_reg)
                        2'd0:
                        begin
                            cur_type_next     = data_byte;
                            cur_handle_next   = '0;
                            struct_start_next = byte_position_reg;
                        end
                        2'd1:    area_length_next = data_byte;
                        2'd2:    cur_handle_next = {cur_handle_reg[15:8], data_byte};
                        default: cur_handle_next = {data_byte, cur_handle_reg[7:0]};
                    endcase
                    if (header_count_reg != 2'd3)
                    begin
                        header_count_next = header_count_reg + 2'd1;
                    end
                    else
                    begin
                        header_count_next   = '0;
                        area_remaining_next = (area_length_reg < 8'd4) ? 8'd0
                                                                       : area_length_reg - 8'd4;
                        seen_null_next      = 1'b0;
                        run_length_next     = '0;
                        string_count_next   = '0;
                        string_start_next   = pos_inc;
                        phase_next = (area_length_reg <= 8'd4) ? PH_STRINGS : PH_AREA;
                    end
                    if (buffer_end)
                    begin
                        phase_next   = PH_HALT;
                        push         = 1'b1;
                        entry.kind0  = smbtw_pkg::KIND_ERROR;
                        entry.err0   = smbtw_pkg::ERR_TRUNCATED;
                    end
                end
                PH_AREA:
                begin
                    area_remaining_next = area_dec;
                    if (area_dec == 8'd0)
                    begin
                        string_start_next = pos_inc;
                        phase_next        = PH_STRINGS;
                    end
                    if (buffer_end)
                    begin
                        phase_next  = PH_HALT;
                        push        = 1'b1;
                        entry.kind0 = smbtw_pkg::KIND_ERROR;
                        entry.err0  = smbtw_pkg::ERR_TRUNCATED;
                    end
                end
                PH_STRINGS:
                begin
                    if (data_byte != 8'd0)
                    begin
                        if (run_length_reg == 16'hFFFF)
                        begin
                            // An overlong string wins over a buffer end.
                            phase_next  = PH_HALT;
                            push        = 1'b1;
                            entry.kind0 = smbtw_pkg::KIND_ERROR;
                            entry.err0  = smbtw_pkg::ERR_STR_LONG;
                        end
                        else
                        begin
                            run_length_next = run_length_reg + 16'd1;
                            seen_null_next  = 1'b0;
                            if (buffer_end)
                            begin
                                phase_next  = PH_HALT;
                                push        = 1'b1;
                                entry.kind0 = smbtw_pkg::KIND_ERROR;
                                entry.err0  = smbtw_pkg::ERR_NO_TERM;
                            end
                        end
                    end
                    else if (seen_null_reg)
                    begin
                        push         = 1'b1;
                        entry.kind0  = smbtw_pkg::KIND_STRUCT_DONE;
                        entry.index0 = string_count_reg;
                        if (cur_type_reg == smbtw_pkg::END_TYPE)
                        begin
                            phase_next  = PH_HALT;
                            entry.has2  = 1'b1;
                            entry.kind1 = smbtw_pkg::KIND_TABLE_DONE;
                        end
                        else if (buffer_end)
                        begin
                            phase_next  = PH_HALT;
                            entry.has2  = 1'b1;
                            entry.kind1 = smbtw_pkg::KIND_ERROR;
                            entry.err1  = smbtw_pkg::ERR_TRUNCATED;
                        end
                        else
                        begin
                            phase_next        = PH_HEADER;
                            header_count_next = '0;
                            struct_start_next = pos_inc;
                        end
                    end
                    else
                    begin
                        seen_null_next    = 1'b1;
                        run_length_next   = '0;
                        string_start_next = pos_inc;
                        // A null right after the formatted area is not a string.
                        if (run_length_reg != 16'd0)
                        begin
                            push              = 1'b1;
                            entry.kind0       = smbtw_pkg::KIND_STRING;
                            entry.index0      = string_count_reg;
                            entry.str_off0    = string_start_reg;
                            entry.str_len0    = run_length_reg;
                            string_count_next = string_count_reg + 8'd1;
                            if (buffer_end)
                            begin
                                phase_next  = PH_HALT;
                                entry.has2  = 1'b1;
                                entry.kind1 = smbtw_pkg::KIND_ERROR;
                                entry.err1  = smbtw_pkg::ERR_NO_TERM;
                            end
                        end
                        else if (buffer_end)
                        begin
                            phase_next  = PH_HALT;
                            push        = 1'b1;
                            entry.kind0 = smbtw_pkg::KIND_ERROR;
                            entry.err0  = smbtw_pkg::ERR_NO_TERM;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            entry.struct_type   = cur_type_next;
            entry.struct_handle = cur_handle_next;
            // The closing null reports the structure it ends, not the next one.
            entry.struct_offset = (phase_reg == PH_HEADER) ? struct_start_next
                                                           : struct_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            header_count_reg   <= '0;
            cur_type_reg       <= '0;
            area_length_reg    <= '0;
            cur_handle_reg     <= '0;
            area_remaining_reg <= '0;
            seen_null_reg      <= 1'b0;
            run_length_reg     <= '0;
            string_count_reg   <= '0;
            string_start_reg   <= '0;
            struct_start_reg   <= '0;
            byte_position_reg  <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            cur_type_reg       <= cur_type_next;
            area_length_reg    <= area_length_next;
            cur_handle_reg     <= cur_handle_next;
            area_remaining_reg <= area_remaining_next;
            seen_null_reg      <= seen_null_next;
            run_length_reg     <= run_length_next;
            string_count_reg   <= string_count_next;
            string_start_reg   <= string_start_next;
            struct_start_reg   <= struct_start_next;
            byte_position_reg  <= byte_position_next;
        end
    end

endmodule

[hdl/smbtw_back.sv]
// ---------------------------------------------------------------------------
// SMBIOS table walker back end
// Pops queue entries and sends their one or two results through the output
// register, one result per transfer.
// ---------------------------------------------------------------------------
module smbtw_back (
    input  logic              clk,
    input  logic              rst_n,
    input  smbtw_pkg::entry_t rdata,
    input  smbtw_pkg::qstat_t qstat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        struct_type,
    output logic [15:0]       struct_handle,
    output logic [31:0]       struct_offset,
    output logic [7:0]        string_index,
    output logic [31:0]       string_offset,
    output logic [15:0]       string_length,
    output logic [1:0]        error_code,
    output logic              run_last
);

    logic              valid_reg,   valid_next;
    logic              pend_reg,    pend_next;
    smbtw_pkg::entry_t hold_reg,    hold_next;
    logic [1:0]        kind_reg,    kind_next;
    logic [7:0]        type_reg,    type_next;
    logic [15:0]       handle_reg,  handle_next;
    logic [31:0]       soff_reg,    soff_next;
    logic [7:0]        index_reg,   index_next;
    logic [31:0]       stroff_reg,  stroff_next;
    logic [15:0]       strlen_reg,  strlen_next;
    logic [1:0]        err_reg,     err_next;
    logic              last_reg,    last_next;
    logic              advance;

    assign advance = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next  = valid_reg;
        pend_next   = pend_reg;
        hold_next   = hold_reg;
        kind_next   = kind_reg;
        type_next   = type_reg;
        handle_next = handle_reg;
        soff_next   = soff_reg;
        index_next  = index_reg;
        stroff_next = stroff_reg;
        strlen_next = strlen_reg;
        err_next    = err_reg;
        last_next   = last_reg;
        pop         = 1'b0;

        if (advance)
        begin
            if (pend_reg)
            begin
                // Second result of the held entry.
                valid_next  = 1'b1;
                pend_next   = 1'b0;
                kind_next   = hold_reg.kind1;
                type_next   = hold_reg.struct_type;
                handle_next = hold_reg.struct_handle;
                soff_next   = hold_reg.struct_offset;
                index_next  = '0;
                stroff_next = '0;
                strlen_next = '0;
                err_next    = hold_reg.err1;
                last_next   = 1'b1;
            end
            else if (!qstat.empty)
            begin
                pop         = 1'b1;
                valid_next  = 1'b1;
                pend_next   = rdata.has2;
                hold_next   = rdata;
                kind_next   = rdata.kind0;
                type_next   = rdata.struct_type;
                handle_next = rdata.struct_handle;
                soff_next   = rdata.struct_offset;
                index_next  = rdata.index0;
                stroff_next = rdata.str_off0;
                strlen_next = rdata.str_len0;
                err_next    = rdata.err0;
                last_next   = !rdata.has2;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        kind_reg   <= kind_next;
        type_reg   <= type_next;
        handle_reg <= handle_next;
        soff_reg   <= soff_next;
        index_reg  <= index_next;
        stroff_reg <= stroff_next;
        strlen_reg <= strlen_next;
        err_reg    <= err_next;
        last_reg   <= last_next;
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign struct_type   = type_reg;
    assign struct_handle = handle_reg;
    assign struct_offset = soff_reg;
    assign string_index  = index_reg;
    assign string_offset = stroff_reg;
    assign string_length = strlen_reg;
    assign error_code    = err_reg;
    assign run_last      = last_reg;

endmodule

[hdl/smbios_table_walker.sv]
// A result goes from the transfer of its byte into a queue slot, then the output register.
// Throughput: one byte per cycle while the queue is not full; the single output register
// sends the two results of a byte in turn, and the four-entry queue absorbs such bursts.
// Reset: rst_n clears the walker state, the queue pointers and the output valid at once;
// there is no clearing pass. After table done or an error, bytes are taken and dropped.
// ---------------------------------------------------------------------------
// SMBIOS table walker
// Walks a raw SMBIOS structure table one byte per transfer and reports
// strings, finished structures, the end of the table and errors.
// ---------------------------------------------------------------------------
module smbios_table_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  struct_type,
    output logic [15:0] struct_handle,
    output logic [31:0] struct_offset,
    output logic [7:0]  string_index,
    output logic [31:0] string_offset,
    output logic [15:0] string_length,
    output logic [1:0]  error_code,
    output logic        run_last
);

    smbtw_pkg::qstat_t qstat;
    smbtw_pkg::entry_t wdata;
    smbtw_pkg::entry_t rdata;
    logic              push;
    logic              pop;

    smbtw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .qstat      (qstat),
        .push       (push),
        .entry      (wdata)
    );

    smbtw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .stat  (qstat)
    );

    smbtw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rdata         (rdata),
        .qstat         (qstat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .struct_type   (struct_type),
        .struct_handle (struct_handle),
        .struct_offset (struct_offset),
        .string_index  (string_index),
        .string_offset (string_offset),
        .string_length (string_length),
        .error_code    (error_code),
        .run_last      (run_last)
    );

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// SMBIOS table walker testbench
// Feeds one raw structure table byte by byte and checks every reported string,
// finished structure, end of table and error against hand-written results and
// a cycle-free walker model kept in the bench. The run opens with a short
// hand-written table and continues with random well-formed structures. It then
// closes the table in one of several ways chosen at random: a clean end, a cut
// in the header or the formatted area, a missing double null, or an overlong
// string. A few bytes after the walker halts make sure they are dropped.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The error code field reads zero in every result that is not an error.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam int BODY_ITEMS = 650;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {PH_HEADER, PH_AREA, PH_STRINGS, PH_HALT} walk_phase_e;
    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_mode_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  struct_type;
        logic [15:0] struct_handle;
        logic [31:0] struct_offset;
        logic [7:0]  string_index;
        logic [31:0] string_offset;
        logic [15:0] string_length;
        logic [1:0]  error_code;
        logic        run_last;
    } walk_result_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         fin;
        row_mode_e    mode;
        walk_result_t typed;
    } dir_row_t;

    // Three short structures: an empty string area with a short length, a
    // formatted area with two strings, and a leading null before a string.
    localparam dir_row_t DIRECTED_ROWS [26] = '{
        '{8'h00, 1'b0, ROW_NONE, '0},
        '{8'h02, 1'b0, ROW_NONE, '0},
        '{8'hFF, 1'b0, ROW_NONE, '0},
        '{8'hFF, 1'b0, ROW_NONE, '0},
        '{8'h00, 1'b0, ROW_NONE, '0},
        '{8'h00, 1'b0, ROW_ONE,
          '{smbtw_pkg::KIND_STRUCT_DONE, 8'h00, 16'hFFFF, 32'd0, 8'd0, 32'd0, 16'd0,
            ERR_NONE, 1'b1}},
        '{8'hFF, 1'b0, ROW_NONE, '0},
        '{8'h06, 1'b0, ROW_NONE, '0},
        '{8'h00, 1'b0, ROW_NONE, '0},
        '{8'h00, 1'b0, ROW_NONE, '0},
        '{8'hAA, 1'b0, ROW_NONE, '0},
        '{8'h55, 1'b0, ROW_NONE, '0},
        '{8'h41, 1'b0, ROW_NONE, '0},
        '{8'h00, 1'b0, ROW_ONE,
          '{smbtw_pkg::KIND_STRING, 8'hFF, 16'h0000, 32'd6, 8'd0, 32'd12, 16'd1,
            ERR_NONE, 1'b1}},
        '{8'h80, 1'b0, ROW_NONE, '0},
        '{8'h7F, 1'b0, ROW_NONE, '0},
        '{8'h00, 1'b0, ROW_ONE,
          '{smbtw_pkg::KIND_STRING, 8'hFF, 16'h0000, 32'd6, 8'd1, 32'd14, 16'd2,
            ERR_NONE, 1'b1}},
        '{8'h00, 1'b0, ROW_ONE,
          '{smbtw_pkg::KIND_STRUCT_DONE, 8'hFF, 16'h0000, 32'd6, 8'd2, 32'd0, 16'd0,
            ERR_NONE, 1'b1}},
        '{8'h01, 1'b0, ROW_PREDICT, '0},
        '{8'h03, 1'b0, ROW_PREDICT, '0},
        '{8'h34, 1'b0, ROW_PREDICT, '0},
        '{8'h12, 1'b0, ROW_PREDICT, '0},
        '{8'h00, 1'b0, ROW_PREDICT, '0},
        '{8'h01, 1'b0, ROW_PREDICT, '0},
        '{8'h00, 1'b0, ROW_PREDICT, '0},
        '{8'h00, 1'b0, ROW_PREDICT, '0}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        buffer_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  struct_type;
    logic [15:0] struct_handle;
    logic [31:0] struct_offset;
    logic [7:0]  string_index;
    logic [31:0] string_offset;
    logic [15:0] string_length;
    logic [1:0]  error_code;
    logic        run_last;

    // Walker model state.
    walk_phase_e walk_phase = PH_HEADER;
    logic [1:0]  hdr_count = '0;
    logic [7:0]  cur_type = '0;
    logic [7:0]  area_len = '0;
    logic [15:0] cur_handle = '0;
    logic [7:0]  area_left = '0;
    logic        seen_null = 1'b0;
    logic [15:0] run_len = '0;
    logic [7:0]  str_count = '0;
    logic [31:0] str_start = '0;
    logic [31:0] struct_start = '0;
    logic [31:0] byte_pos = '0;

    walk_result_t pending_results [$];
    logic [7:0]   struct_bytes [$];
    int           strings_at;
    int           sent_count = 0;
    int           rx_count = 0;
    int           fail_count = 0;
    int           quiet_cycles = 0;

    smbios_table_walker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .buffer_end    (buffer_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .struct_type   (struct_type),
        .struct_handle (struct_handle),
        .struct_offset (struct_offset),
        .string_index  (string_index),
        .string_offset (string_offset),
        .string_length (string_length),
        .error_code    (error_code),
        .run_last      (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit roll_idle(input bit calm);
        return !calm && ($urandom_range(99, 0) < 18);
    endfunction

    function automatic walk_result_t ctx_result(input logic [1:0] k, input logic [7:0] idx,
                                                input logic [31:0] soff,
                                                input logic [15:0] slen,
                                                input logic [1:0] err);
        walk_result_t r;
        r.kind          = k;
        r.struct_type   = cur_type;
        r.struct_handle = cur_handle;
        r.struct_offset = struct_start;
        r.string_index  = idx;
        r.string_offset = soff;
        r.string_length = slen;
        r.error_code    = err;
        r.run_last      = 1'b0;
        return r;
    endfunction

    function automatic walk_result_t halt_with(input logic [1:0] err);
        walk_phase = PH_HALT;
        return ctx_result(smbtw_pkg::KIND_ERROR, 8'd0, 32'd0, 16'd0, err);
    endfunction

    // Advances the walker model by one byte and returns the results it causes.
    function automatic int predict_byte(input logic [7:0] b, input logic fin,
                                        output walk_result_t r0, output walk_result_t r1);
        logic [31:0]  pos;
        walk_result_t res [2];
        int           n;
        pos = byte_pos;
        byte_pos = pos + 32'd1;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        case (walk_phase)
            PH_HEADER:
            begin
                case (hdr_count)
                    2'd0:
                    begin
                        cur_type = b;
                        cur_handle = '0;
                        struct_start = pos;
                    end
                    2'd1: area_len = b;
                    2'd2: cur_handle[7:0] = b;
                    default: cur_handle[15:8] = b;
                endcase
                if (hdr_count != 2'd3)
                    hdr_count = hdr_count + 2'd1;
                else
                begin
                    hdr_count = 2'd0;
                    area_left = (area_len < 8'd4) ? 8'd0 : area_len - 8'd4;
                    seen_null = 1'b0;
                    run_len = '0;
                    str_count = '0;
                    str_start = pos + 32'd1;
                    walk_phase = (area_left == 8'd0) ? PH_STRINGS : PH_AREA;
                end
                if (fin)
                begin
                    res[n] = halt_with(smbtw_pkg::ERR_TRUNCATED);
                    n++;
                end
            end
            PH_AREA:
            begin
                area_left = area_left - 8'd1;
                if (area_left == 8'd0)
                begin
                    str_start = pos + 32'd1;
                    walk_phase = PH_STRINGS;
                end
                if (fin)
                begin
                    res[n] = halt_with(smbtw_pkg::ERR_TRUNCATED);
                    n++;
                end
            end
            PH_STRINGS:
            begin
                if (b != 8'd0)
                begin
                    // The overlong check wins over a buffer end on the same byte.
                    if (run_len == 16'hFFFF)
                    begin
                        res[n] = halt_with(smbtw_pkg::ERR_STR_LONG);
                        n++;
                    end
                    else
                    begin
                        run_len = run_len + 16'd1;
                        seen_null = 1'b0;
                        if (fin)
                        begin
                            res[n] = halt_with(smbtw_pkg::ERR_NO_TERM);
                            n++;
                        end
                    end
                end
                else if (seen_null)
                begin
                    res[n] = ctx_result(smbtw_pkg::KIND_STRUCT_DONE, str_count, 32'd0, 16'd0,
                                        ERR_NONE);
                    n++;
                    if (cur_type == smbtw_pkg::END_TYPE)
                    begin
                        walk_phase = PH_HALT;
                        res[n] = ctx_result(smbtw_pkg::KIND_TABLE_DONE, 8'd0, 32'd0, 16'd0,
                                            ERR_NONE);
                        n++;
                    end
                    else if (fin)
                    begin
                        res[n] = halt_with(smbtw_pkg::ERR_TRUNCATED);
                        n++;
                    end
                    else
                    begin
                        walk_phase = PH_HEADER;
                        hdr_count = 2'd0;
                        struct_start = pos + 32'd1;
                    end
                end
                else
                begin
                    // A null right at the start of the string area ends no string.
                    if (run_len != 16'd0)
                    begin
                        res[n] = ctx_result(smbtw_pkg::KIND_STRING, str_count, str_start,
                                            run_len, ERR_NONE);
                        n++;
                        str_count = str_count + 8'd1;
                    end
                    seen_null = 1'b1;
                    run_len = '0;
                    str_start = pos + 32'd1;
                    if (fin)
                    begin
                        res[n] = halt_with(smbtw_pkg::ERR_NO_TERM);
                        n++;
                    end
                end
            end
            default: ;
        endcase
        if (n > 0)
            res[n - 1].run_last = 1'b1;
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input row_mode_e mode,
                             input walk_result_t typed);
        walk_result_t r0;
        walk_result_t r1;
        int           n;
        bit           calm;
        calm = sent_count >= 120 && sent_count < 320;
        if (roll_idle(calm))
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (roll_idle(calm));
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        buffer_end <= fin;
        do @(posedge clk); while (in_stall);
        sent_count++;
        n = predict_byte(b, fin, r0, r1);
        case (mode)
            ROW_PREDICT:
            begin
                if (n > 0)
                    pending_results.push_back(r0);
                if (n > 1)
                    pending_results.push_back(r1);
            end
            ROW_ONE: pending_results.push_back(typed);
            default: ;
        endcase
    endtask

    // Lays out one structure: header, random formatted area, an optional leading
    // null, then nstr strings of lo..hi characters each and the closing null.
    task automatic build_struct(input logic [7:0] stype, input logic [7:0] len_byte,
                                input logic [15:0] handle, input int nstr, input int lo,
                                input int hi, input bit lead_null);
        int area_n;
        int slen;
        struct_bytes = {};
        struct_bytes.push_back(stype);
        struct_bytes.push_back(len_byte);
        struct_bytes.push_back(handle[7:0]);
        struct_bytes.push_back(handle[15:8]);
        area_n = (len_byte < 8'd4) ? 0 : int'(len_byte) - 4;
        repeat (area_n) struct_bytes.push_back(8'($urandom));
        strings_at = struct_bytes.size();
        if (lead_null || nstr == 0)
            struct_bytes.push_back(8'h00);
        repeat (nstr)
        begin
            slen = $urandom_range(hi, lo);
            repeat (slen) struct_bytes.push_back(8'($urandom_range(255, 1)));
            struct_bytes.push_back(8'h00);
        end
        struct_bytes.push_back(8'h00);
    endtask

    task automatic random_struct(input logic [7:0] stype, input int min_strings);
        int          pick;
        logic [7:0]  len;
        pick = $urandom_range(99, 0);
        if (pick < 25)
            len = 8'($urandom_range(4, 0));
        else if (pick < 85)
            len = 8'($urandom_range(24, 5));
        else
            len = 8'($urandom_range(255, 25));
        build_struct(stype, len, 16'($urandom), $urandom_range(5, min_strings), 1, 10,
                     $urandom_range(3, 0) == 0);
    endtask

    // Sends the built structure up to and including byte cut (all when cut
    // is negative); buffer_end goes with the cut byte when fin is set.
    task automatic send_struct(input int cut, input logic fin);
        int i;
        for (i = 0; i < struct_bytes.size() && (cut < 0 || i <= cut); i++)
            send_byte(struct_bytes[i], fin && (i == cut), ROW_PREDICT, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
        out_stall <= roll_idle(rx_count >= 20 && rx_count < 80);

    always @(posedge clk)
    begin
        walk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            rx_count <= rx_count + 1;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: kind %0d", kind);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("struct_type", 32'(want.struct_type), 32'(struct_type));
                check_field("struct_handle", 32'(want.struct_handle), 32'(struct_handle));
                check_field("struct_offset", want.struct_offset, struct_offset);
                check_field("string_index", 32'(want.string_index), 32'(string_index));
                check_field("string_offset", want.string_offset, string_offset);
                check_field("string_length", 32'(want.string_length), 32'(string_length));
                check_field("error_code", 32'(want.error_code), 32'(error_code));
                check_field("run_last", 32'(want.run_last), 32'(run_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] t;
        int         cut;
        int         long_len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].mode,
                      DIRECTED_ROWS[i].typed);

        while (sent_count < BODY_ITEMS)
        begin
            do t = 8'($urandom); while (t == smbtw_pkg::END_TYPE);
            random_struct(t, 0);
            send_struct(-1, 1'b0);
        end

        // Enough strings in one structure to wrap the string index.
        if ($urandom_range(1, 0) == 1)
        begin
            build_struct(8'($urandom_range(126, 0)), 8'd4, 16'($urandom),
                         $urandom_range(300, 257), 1, 2, 1'b0);
            send_struct(-1, 1'b0);
        end
        if ($urandom_range(1, 0) == 1)
        begin
            long_len = ($urandom_range(1, 0) == 1) ? 65535 : $urandom_range(65534, 256);
            build_struct(8'($urandom_range(255, 128)), 8'($urandom_range(8, 0)),
                         16'($urandom), 1, long_len, long_len, 1'b0);
            send_struct(-1, 1'b0);
        end

        do t = 8'($urandom); while (t == smbtw_pkg::END_TYPE);
        case ($urandom_range(6, 0))
            0:
            begin
                random_struct(smbtw_pkg::END_TYPE, 0);
                send_struct(struct_bytes.size() - 1, 1'($urandom_range(1, 0)));
            end
            1:
            begin
                random_struct(t, 0);
                send_struct($urandom_range(3, 0), 1'b1);
            end
            2:
            begin
                build_struct(t, 8'($urandom_range(40, 5)), 16'($urandom), 2, 1, 6, 1'b0);
                send_struct($urandom_range(strings_at - 1, 4), 1'b1);
            end
            3:
            begin
                random_struct(t, 1);
                do cut = $urandom_range(struct_bytes.size() - 2, strings_at);
                while (struct_bytes[cut] == 8'h00);
                send_struct(cut, 1'b1);
            end
            4:
            begin
                random_struct(t, 0);
                do cut = $urandom_range(struct_bytes.size() - 2, strings_at);
                while (struct_bytes[cut] != 8'h00);
                send_struct(cut, 1'b1);
            end
            5:
            begin
                build_struct(t, 8'($urandom_range(6, 0)), 16'($urandom), 1, 65536, 65536,
                             1'b0);
                send_struct(strings_at + 65535, 1'($urandom_range(1, 0)));
            end
            default:
            begin
                random_struct(t, 0);
                send_struct(struct_bytes.size() - 1, 1'b1);
            end
        endcase

        // The walker has halted; these bytes must cause nothing.
        repeat (16) send_byte(8'($urandom), 1'($urandom_range(1, 0)), ROW_PREDICT, '0);
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/smbtw_pkg.sv
hdl/smbtw_queue.sv
hdl/smbtw_front.sv
hdl/smbtw_back.sv
hdl/smbios_table_walker.sv
sim/tb.sv
